// ===== hdl/eida_pkg.sv =====
// ----------------------------------------------------------------------------
// eida_pkg: shared definitions for the entity id allocator
// Port widths, default sizes, operation and status codes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package eida_pkg;

   // Fixed payload widths of the request, response and register ports
   localparam int OP_W        = 2;
   localparam int ENTITY_W    = 10;
   localparam int SIG_PORT_W  = 32;
   localparam int MEMB_W      = 4;
   localparam int LIVE_W      = 11;
   localparam int STATUS_W    = 2;
   localparam int CSR_DATA_W  = 32;

   // System mask registers on the register port
   localparam int NUM_MASK_REGS = 4;
   localparam int CSR_INDEX_W   = $clog2(NUM_MASK_REGS);

   // Default sizes
   localparam int DEF_CAPACITY       = 1024;
   localparam int DEF_SIGNATURE_BITS = 32;
   localparam int DEF_NUM_SYSTEMS    = 4;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE  = 2'd0,
      OP_DESTROY = 2'd1,
      OP_SET_SIG = 2'd2,
      OP_GET_SIG = 2'd3
   } eida_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_NO_FREE  = 2'd1,
      STS_RANGE    = 2'd2,
      STS_NOT_LIVE = 2'd3
   } eida_status_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;   // write one entry of the reset sweep
      logic accept;       // request transfer this cycle, launch first read
      logic fetch;        // free id is out, read its entity entry
      logic commit;       // update tables and load the response
   } eida_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;   // sweep is at the last entry
      logic out_free;     // response register can take a result
   } eida_stat_type;

endpackage

// ===== hdl/eida_ram.sv =====
// ----------------------------------------------------------------------------
// eida_ram: generic simple dual-port RAM
// One write port, one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module eida_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/eida_ctrl.sv =====
// ----------------------------------------------------------------------------
// eida_ctrl: sequencer for the entity id allocator
// Runs the reset sweep, takes one request at a time and steps it through
// the table reads and the commit.
// ----------------------------------------------------------------------------
module eida_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [eida_pkg::OP_W-1:0] req_operation,
   output eida_pkg::eida_cmd_type    cmd,
   input  eida_pkg::eida_stat_type   stat
);
   import eida_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Commands follow the current state
   always_comb begin
      cmd            = '0;
      cmd.clear_step = (state_ff == S_CLEAR);
      cmd.accept     = accept;
      cmd.fetch      = (state_ff == S_FETCH);
      cmd.commit     = (state_ff == S_LOOKUP) && stat.out_free;
   end

   // Next state: create takes the extra free-id read
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (eida_op_type'(req_operation) == OP_CREATE) begin
                  state_in = S_FETCH;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_FETCH: begin
            state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/eida_dpath.sv =====
// ----------------------------------------------------------------------------
// eida_dpath: tables, pointers and response register of the allocator
// Holds the free-id FIFO RAM, the entity RAM (live flag, signature,
// membership), the mask registers, the counters and the result register.
// ----------------------------------------------------------------------------
module eida_dpath #(
   parameter int CAPACITY       = eida_pkg::DEF_CAPACITY,
   parameter int SIGNATURE_BITS = eida_pkg::DEF_SIGNATURE_BITS,
   parameter int NUM_SYSTEMS    = eida_pkg::DEF_NUM_SYSTEMS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  eida_pkg::eida_cmd_type           cmd,
   output eida_pkg::eida_stat_type          stat,
   input  logic [eida_pkg::OP_W-1:0]        req_operation,
   input  logic [eida_pkg::ENTITY_W-1:0]    req_entity,
   input  logic [eida_pkg::SIG_PORT_W-1:0]  req_signature,
   input  logic                             csr_write_en,
   input  logic [eida_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [eida_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [eida_pkg::ENTITY_W-1:0]    rsp_entity_id,
   output logic [eida_pkg::SIG_PORT_W-1:0]  rsp_signature_out,
   output logic [eida_pkg::MEMB_W-1:0]      rsp_membership,
   output logic [eida_pkg::LIVE_W-1:0]      rsp_live_total,
   output logic [eida_pkg::STATUS_W-1:0]    rsp_status
);
   import eida_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ENT_W  = SIGNATURE_BITS + NUM_SYSTEMS + 1;

   // Registers
   logic [SIGNATURE_BITS-1:0] mask_ff [NUM_MASK_REGS];
   logic [ADDR_W-1:0]         clr_cnt_ff;
   logic [ADDR_W-1:0]         head_ff, head_in;
   logic [ADDR_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]          live_ff, live_in;
   logic [OP_W-1:0]           op_ff;
   logic [ENTITY_W-1:0]       ent_ff;
   logic [SIGNATURE_BITS-1:0] sig_ff;
   logic                      rsp_valid_ff;
   logic [ENTITY_W-1:0]       rsp_id_ff;
   logic [SIGNATURE_BITS-1:0] rsp_sig_ff;
   logic [NUM_SYSTEMS-1:0]    rsp_mem_ff;
   logic [CNT_W-1:0]          rsp_live_ff;
   eida_status_type           rsp_sts_ff;

   // RAM ports
   logic                  free_we, free_re;
   logic [ADDR_W-1:0]     free_waddr, free_wdata, free_rdata;
   logic                  ent_we, ent_re;
   logic [ADDR_W-1:0]     ent_waddr, ent_raddr;
   logic [ENT_W-1:0]      ent_wdata, ent_rdata;

   // Commit logic
   logic [SIGNATURE_BITS-1:0] sys_mask [NUM_SYSTEMS];
   logic [NUM_SYSTEMS-1:0]    new_mem;
   logic                      rd_live;
   logic [SIGNATURE_BITS-1:0] rd_sig;
   logic [NUM_SYSTEMS-1:0]    rd_mem;
   logic [ADDR_W-1:0]         ent_idx_ff;
   logic                      in_range;
   logic                      full;
   logic                      upd_ent_we, upd_free_we;
   logic [ADDR_W-1:0]         upd_ent_addr;
   logic [ENT_W-1:0]          upd_ent_data;
   logic [ENTITY_W-1:0]       res_id;
   logic [SIGNATURE_BITS-1:0] res_sig;
   logic [NUM_SYSTEMS-1:0]    res_mem;
   eida_status_type           res_sts;

   function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] q;
      if (p == ADDR_W'(CAPACITY - 1)) begin
         q = '0;
      end else begin
         q = p + 1'b1;
      end
      return q;
   endfunction

   // Write the system mask registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MASK_REGS; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         mask_ff[csr_index] <= SIGNATURE_BITS'(csr_data);
      end
   end

   // Systems past the register set require nothing
   for (genvar k = 0; k < NUM_SYSTEMS; k++) begin : g_sys
      if (k < NUM_MASK_REGS) begin : g_reg
         assign sys_mask[k] = mask_ff[k];
      end else begin : g_zero
         assign sys_mask[k] = '0;
      end
   end

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_operation;
         ent_ff <= req_entity;
         sig_ff <= SIGNATURE_BITS'(req_signature);
      end
   end

   assign ent_idx_ff = ADDR_W'(ent_ff);
   assign in_range   = 32'(ent_ff) < CAPACITY;
   assign full       = (live_ff == CNT_W'(CAPACITY));

   // Split the entity word
   assign rd_live = ent_rdata[ENT_W-1];
   assign rd_sig  = ent_rdata[NUM_SYSTEMS +: SIGNATURE_BITS];
   assign rd_mem  = ent_rdata[NUM_SYSTEMS-1:0];

   // Membership: signature covers each system's mask
   always_comb begin
      for (int k = 0; k < NUM_SYSTEMS; k++) begin
         new_mem[k] = ((sig_ff & sys_mask[k]) == sys_mask[k]);
      end
   end

   // Decide the result and the table updates of the held request
   always_comb begin
      res_id       = ent_ff;
      res_sig      = '0;
      res_mem      = '0;
      res_sts      = STS_OK;
      upd_ent_we   = 1'b0;
      upd_ent_addr = ent_idx_ff;
      upd_ent_data = ent_rdata;
      upd_free_we  = 1'b0;
      head_in      = head_ff;
      tail_in      = tail_ff;
      live_in      = live_ff;
      case (eida_op_type'(op_ff))
         OP_CREATE: begin
            if (full) begin
               res_id  = '0;
               res_sts = STS_NO_FREE;
            end else begin
               res_id       = ENTITY_W'(free_rdata);
               res_sig      = rd_sig;
               res_mem      = rd_mem;
               upd_ent_we   = 1'b1;
               upd_ent_addr = free_rdata;
               upd_ent_data = {1'b1, rd_sig, rd_mem};
               head_in      = wrap_next(head_ff);
               live_in      = live_ff + 1'b1;
            end
         end
         OP_DESTROY: begin
            if (!in_range) begin
               res_sts = STS_RANGE;
            end else if (!rd_live) begin
               res_sig = rd_sig;
               res_mem = rd_mem;
               res_sts = STS_NOT_LIVE;
            end else begin
               upd_ent_we   = 1'b1;
               upd_ent_data = '0;
               upd_free_we  = 1'b1;
               tail_in      = wrap_next(tail_ff);
               live_in      = live_ff - 1'b1;
            end
         end
         OP_SET_SIG: begin
            if (!in_range) begin
               res_sts = STS_RANGE;
            end else begin
               res_sig      = sig_ff;
               res_mem      = new_mem;
               upd_ent_we   = 1'b1;
               upd_ent_data = {rd_live, sig_ff, new_mem};
            end
         end
         OP_GET_SIG: begin
            if (!in_range) begin
               res_sts = STS_RANGE;
            end else begin
               res_sig = rd_sig;
               res_mem = rd_mem;
            end
         end
         default: begin
            res_sts = STS_OK;
         end
      endcase
   end

   // Steer the RAM ports: sweep, commit and reads
   assign free_we    = cmd.clear_step || (cmd.commit && upd_free_we);
   assign free_waddr = cmd.clear_step ? clr_cnt_ff : tail_ff;
   assign free_wdata = cmd.clear_step ? clr_cnt_ff : ent_idx_ff;
   assign free_re    = cmd.accept && (eida_op_type'(req_operation) == OP_CREATE);

   assign ent_we    = cmd.clear_step || (cmd.commit && upd_ent_we);
   assign ent_waddr = cmd.clear_step ? clr_cnt_ff : upd_ent_addr;
   assign ent_wdata = cmd.clear_step ? '0 : upd_ent_data;
   assign ent_re    = cmd.fetch ||
                      (cmd.accept && (eida_op_type'(req_operation) != OP_CREATE));
   assign ent_raddr = cmd.fetch ? free_rdata : ADDR_W'(req_entity);

   eida_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (CAPACITY)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_waddr),
      .wr_data (free_wdata),
      .rd_en   (free_re),
      .rd_addr (head_ff),
      .rd_data (free_rdata)
   );

   eida_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // Advance the sweep counter and the FIFO pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         live_ff    <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= wrap_next(clr_cnt_ff);
         end
         if (cmd.commit) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            live_ff <= live_in;
         end
      end
   end

   // Response register: load on commit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_id_ff   <= res_id;
         rsp_sig_ff  <= res_sig;
         rsp_mem_ff  <= res_mem;
         rsp_live_ff <= live_in;
         rsp_sts_ff  <= res_sts;
      end
   end

   assign stat.clear_last = (clr_cnt_ff == ADDR_W'(CAPACITY - 1));
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entity_id     = rsp_id_ff;
   assign rsp_signature_out = SIG_PORT_W'(rsp_sig_ff);
   assign rsp_membership    = MEMB_W'(rsp_mem_ff);
   assign rsp_live_total    = LIVE_W'(rsp_live_ff);
   assign rsp_status        = rsp_sts_ff;

endmodule

// ===== hdl/entity_id_allocator_signature_match.sv =====
// ----------------------------------------------------------------------------
// entity_id_allocator_signature_match: entity id allocator with signatures
// Hands out entity ids from a FIFO of free ids, keeps a component signature
// and a system membership mask per entity, and reports one result per
// request. After reset the block runs a clearing pass over all CAPACITY
// entries (one entry of the free-id RAM and the entity RAM per cycle)
// before req_ready rises; mask registers can be written throughout. For
// destroy, set and get the transfer launches the entity RAM read and the
// commit follows; create first reads the free-id RAM, which must complete
// before the entity RAM can be read at that id. The result sits in an output
// register; the next request is taken once the previous result has been
// loaded there, and a stalled response holds the block in its commit cycle.
// ----------------------------------------------------------------------------
module entity_id_allocator_signature_match #(
   parameter int CAPACITY       = eida_pkg::DEF_CAPACITY,
   parameter int SIGNATURE_BITS = eida_pkg::DEF_SIGNATURE_BITS,
   parameter int NUM_SYSTEMS    = eida_pkg::DEF_NUM_SYSTEMS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [eida_pkg::OP_W-1:0]        req_operation,
   input  logic [eida_pkg::ENTITY_W-1:0]    req_entity,
   input  logic [eida_pkg::SIG_PORT_W-1:0]  req_signature,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [eida_pkg::ENTITY_W-1:0]    rsp_entity_id,
   output logic [eida_pkg::SIG_PORT_W-1:0]  rsp_signature_out,
   output logic [eida_pkg::MEMB_W-1:0]      rsp_membership,
   output logic [eida_pkg::LIVE_W-1:0]      rsp_live_total,
   output logic [eida_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                             csr_write_en,
   input  logic [eida_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [eida_pkg::CSR_DATA_W-1:0]  csr_data
);
   import eida_pkg::*;

   eida_cmd_type  cmd;
   eida_stat_type stat;

   eida_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .cmd           (cmd),
      .stat          (stat)
   );

   eida_dpath #(
      .CAPACITY       (CAPACITY),
      .SIGNATURE_BITS (SIGNATURE_BITS),
      .NUM_SYSTEMS    (NUM_SYSTEMS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_entity        (req_entity),
      .req_signature     (req_signature),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_entity_id     (rsp_entity_id),
      .rsp_signature_out (rsp_signature_out),
      .rsp_membership    (rsp_membership),
      .rsp_live_total    (rsp_live_total),
      .rsp_status        (rsp_status)
   );

endmodule
